// File: rtl/core/pfbpfa_pkg.sv
// Shared types, codes and helpers for the PFB to PFA converter.
// Used by the front, queue, back and top-level modules; no dependencies.

package pfbpfa_pkg;

  // Parser phase of the front end.
  typedef enum logic [2:0] {
    PH_MARKER,
    PH_TYPE,
    PH_LENGTH,
    PH_DATA,
    PH_HALT
  } phase_e;

  // What the back end has to expand for one queued entry.
  typedef enum logic {
    CMD_SINGLE,
    CMD_HEX
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [1:0]  status;
    logic [7:0]  data;
    logic        line_lf;
    logic        end_lf;
  } cmd_t;

  localparam logic [1:0] ST_CHAR       = 2'd0;
  localparam logic [1:0] ST_END        = 2'd1;
  localparam logic [1:0] ST_BAD_MARKER = 2'd2;
  localparam logic [1:0] ST_BAD_TYPE   = 2'd3;

  localparam logic [7:0] SEG_MARKER = 8'd128;
  localparam logic [7:0] SEG_TEXT   = 8'd1;
  localparam logic [7:0] SEG_BINARY = 8'd2;
  localparam logic [7:0] SEG_END    = 8'd3;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] BPL_RESET  = 8'd30;

  // Lowercase ASCII hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = {4'h3, nib};
    end else begin
      res = 8'h57 + {4'h0, nib};
    end
    return res;
  endfunction

endpackage

// File: rtl/core/pfbpfa_front.sv
// Front end of the PFB to PFA converter: segment header parser and line counter.
// Turns each accepted byte into at most one queue entry. Depends on pfbpfa_pkg.

module pfbpfa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              full_i,
  output logic              push_o,
  output pfbpfa_pkg::cmd_t  cmd_o
);
  import pfbpfa_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  len_cnt_q, len_cnt_d;
  logic        binary_q, binary_d;
  logic [31:0] remaining_q, remaining_d;
  logic [7:0]  col_q, col_d;
  logic [7:0]  bpl_q;

  logic        accept;
  logic [31:0] full_len;
  logic        len_zero;
  logic [7:0]  col_next;
  logic        line_lf;
  logic        seg_last;

  assign accept   = in_valid_i && !full_i;
  assign full_len = {data_byte_i, remaining_q[23:0]};
  // A length with its top bit set counts as an empty segment.
  assign len_zero = data_byte_i[7] || (full_len == 32'd0);
  // A line size of zero behaves as 256 because the column wraps.
  assign col_next = col_q + 8'd1;
  assign line_lf  = (col_next == bpl_q);
  assign seg_last = (remaining_q == 32'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpl_q <= BPL_RESET;
    end else if (cfg_valid_i) begin
      bpl_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MARKER;
      len_cnt_q   <= 2'd0;
      binary_q    <= 1'b0;
      remaining_q <= 32'd0;
      col_q       <= 8'd0;
    end else begin
      phase_q     <= phase_d;
      len_cnt_q   <= len_cnt_d;
      binary_q    <= binary_d;
      remaining_q <= remaining_d;
      col_q       <= col_d;
    end
  end

  // Next state.
  always_comb begin
    phase_d     = phase_q;
    len_cnt_d   = len_cnt_q;
    binary_d    = binary_q;
    remaining_d = remaining_q;
    col_d       = col_q;
    if (accept) begin
      unique case (phase_q)
        PH_MARKER: begin
          phase_d = (data_byte_i == SEG_MARKER) ? PH_TYPE : PH_HALT;
        end
        PH_TYPE: begin
          if (data_byte_i == SEG_TEXT || data_byte_i == SEG_BINARY) begin
            binary_d    = (data_byte_i == SEG_BINARY);
            len_cnt_d   = 2'd0;
            remaining_d = 32'd0;
            col_d       = 8'd0;
            phase_d     = PH_LENGTH;
          end else begin
            phase_d = PH_HALT;
          end
        end
        PH_LENGTH: begin
          unique case (len_cnt_q)
            2'd0: remaining_d = {remaining_q[31:8], data_byte_i};
            2'd1: remaining_d = {remaining_q[31:16], data_byte_i, remaining_q[7:0]};
            2'd2: remaining_d = {remaining_q[31:24], data_byte_i, remaining_q[15:0]};
            default: begin
              remaining_d = len_zero ? 32'd0 : full_len;
              phase_d     = len_zero ? PH_MARKER : PH_DATA;
            end
          endcase
          len_cnt_d = len_cnt_q + 2'd1;
        end
        PH_DATA: begin
          remaining_d = remaining_q - 32'd1;
          if (binary_q) begin
            col_d = line_lf ? 8'd0 : col_next;
          end
          if (seg_last) begin
            phase_d = PH_MARKER;
          end
        end
        PH_HALT: begin
          phase_d = PH_HALT;
        end
        default: begin
          phase_d = PH_HALT;
        end
      endcase
    end
  end

  // Queue entry for the accepted byte.
  always_comb begin
    push_o        = 1'b0;
    cmd_o.kind    = CMD_SINGLE;
    cmd_o.status  = ST_CHAR;
    cmd_o.data    = 8'd0;
    cmd_o.line_lf = 1'b0;
    cmd_o.end_lf  = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_MARKER: begin
          if (data_byte_i != SEG_MARKER) begin
            push_o       = 1'b1;
            cmd_o.status = ST_BAD_MARKER;
          end
        end
        PH_TYPE: begin
          if (data_byte_i == SEG_END) begin
            push_o       = 1'b1;
            cmd_o.status = ST_END;
          end else if (data_byte_i != SEG_TEXT && data_byte_i != SEG_BINARY) begin
            push_o       = 1'b1;
            cmd_o.status = ST_BAD_TYPE;
          end
        end
        PH_LENGTH: begin
          // An empty binary segment still closes with a line feed.
          if (len_cnt_q == 2'd3 && len_zero && binary_q) begin
            push_o     = 1'b1;
            cmd_o.data = CH_LF;
          end
        end
        PH_DATA: begin
          push_o = 1'b1;
          if (binary_q) begin
            cmd_o.kind    = CMD_HEX;
            cmd_o.data    = data_byte_i;
            cmd_o.line_lf = line_lf;
            cmd_o.end_lf  = seg_last;
          end else begin
            cmd_o.data = (data_byte_i == CH_CR) ? CH_LF : data_byte_i;
          end
        end
        PH_HALT: begin
          push_o = 1'b0;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT) |=> (phase_q == PH_HALT))
    else $error("front left the halted phase");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("front pushed into a full queue");

  a_data_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (remaining_q != 32'd0 && !remaining_q[31]))
    else $error("data phase with no bytes remaining");

endmodule

// File: rtl/core/pfbpfa_queue.sv
// Short first-in first-out queue of commands between the front and back ends.
// Depends on pfbpfa_pkg for the entry type.

module pfbpfa_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfbpfa_pkg::cmd_t  push_data_i,
  input  logic              pop_i,
  output pfbpfa_pkg::cmd_t  head_o,
  output logic              empty_o,
  output logic              full_o
);
  import pfbpfa_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign empty_o = (count_q == CntW'(0));
  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue occupancy out of range");

endmodule

// File: rtl/core/pfbpfa_back.sv
// Back end of the PFB to PFA converter: expands queued commands into
// characters and status results behind an output register. Depends on pfbpfa_pkg.

module pfbpfa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfbpfa_pkg::cmd_t  head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_char_o,
  output logic [1:0]        status_o,
  output logic              last_o
);
  import pfbpfa_pkg::*;

  logic [1:0] step_q, step_d;
  logic       out_valid_q;
  logic [7:0] char_q;
  logic [1:0] status_q;
  logic       last_q;

  logic       load;
  logic [7:0] res_char;
  logic [1:0] res_status;
  logic       res_last;

  // A new result enters when the output register is free or being emptied.
  assign load = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    res_char   = head_i.data;
    res_status = head_i.status;
    res_last   = 1'b1;
    if (head_i.kind == CMD_HEX) begin
      res_status = ST_CHAR;
      unique case (step_q)
        2'd0: begin
          res_char = hex_char(head_i.data[7:4]);
          res_last = 1'b0;
        end
        2'd1: begin
          res_char = hex_char(head_i.data[3:0]);
          res_last = !(head_i.line_lf || head_i.end_lf);
        end
        2'd2: begin
          // Line break or segment end; both only when a line closes the segment.
          res_char = CH_LF;
          res_last = !(head_i.line_lf && head_i.end_lf);
        end
        default: begin
          res_char = CH_LF;
          res_last = 1'b1;
        end
      endcase
    end
  end

  assign pop_o  = load && res_last;
  assign step_d = load ? (res_last ? 2'd0 : step_q + 2'd1) : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q   <= res_char;
      status_q <= res_status;
      last_q   <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = char_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> (step_q == 2'd0))
    else $error("expansion in progress with an empty queue");

  a_step_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == 2'd3) |-> (head_i.kind == CMD_HEX && head_i.line_lf && head_i.end_lf))
    else $error("fourth result for a command that has only three");

endmodule

// File: rtl/core/pfb_to_pfa_converter.sv
// Top level of the PFB to PFA converter.
// Instantiates pfbpfa_front, pfbpfa_queue and pfbpfa_back; uses pfbpfa_pkg.

// Converts a Type 1 font stream in PFB form into PFA text, one input byte per
// transfer. Each text byte gives one character; a binary byte becomes two
// lowercase hex characters plus an inserted line feed after every bytes_per_line
// bytes and one more at the end of the segment, so it occupies the
// single-character output port for 2 to 4 results. The output port is what
// limits the sustained rate. A queue of QueueDepth commands lets the parser run
// ahead of the character output; while the queue is full every input byte
// waits, header bytes included. Each result carries a status (character, end
// segment, bad marker, unknown type) and a last flag on the final result of its
// input byte. After an end segment or an error every further byte is accepted
// and dropped until reset. bytes_per_line is to be written through the
// configuration channel, which is always ready, while the block is idle; the
// block itself does not enforce this. Zero behaves as 256.

module pfb_to_pfa_converter #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic [1:0] status_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  import pfbpfa_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  assign in_stall_o  = q_full;
  assign cfg_ready_o = 1'b1;

  pfbpfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  pfbpfa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  pfbpfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
